// ----- hdl/cltfp_pkg.sv -----
// Shared constants, types and tables for the complex literal parser.
package cltfp_pkg;

    // Fixed-point format and fraction digit limit
    localparam int INT_BITS        = 16;
    localparam int FRAC_BITS       = 24;
    localparam int MAX_FRAC_DIGITS = 8;

    localparam int WHOLE_W = INT_BITS - 1;
    localparam int OUT_W   = INT_BITS + FRAC_BITS;
    localparam int FD_W    = $clog2(10 ** MAX_FRAC_DIGITS);
    localparam int P_W     = $clog2(10 ** MAX_FRAC_DIGITS + 1);
    localparam int FC_W    = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int CNT_W   = $clog2(FRAC_BITS);

    localparam logic [WHOLE_W-1:0] WHOLE_MAX = '1;
    localparam logic [3:0]         RADIX     = 4'd10;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_I     = 8'd105;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;

    typedef enum logic [3:0] {
        PH_R_START,
        PH_R_SIGNED,
        PH_R_INT,
        PH_R_FRAC,
        PH_I_START,
        PH_I_INT,
        PH_I_FRAC,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [2:0] {
        ST_PARSE,
        ST_DIV_RE,
        ST_SWAP,
        ST_DIV_IM,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic parse;
        logic start_re;
        logic step;
        logic start_im;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic done_next;
        logic div_last;
        logic out_free;
    } t_sts;

    typedef logic [P_W-1:0] t_pow10_tab [0:(1 << FC_W)-1];

    function automatic t_pow10_tab f_pow10_tab();
        t_pow10_tab tab;
        longint     p;
        p = 1;
        for (int k = 0; k < (1 << FC_W); k++) begin
            tab[k] = (k <= MAX_FRAC_DIGITS) ? P_W'(p) : P_W'(1);
            if (k < MAX_FRAC_DIGITS) begin
                p = p * 10;
            end
        end
        return tab;
    endfunction

    localparam t_pow10_tab POW10 = f_pow10_tab();

endpackage

// ----- hdl/cltfp_ctrl.sv -----
// Sequencer: character parsing, two fraction divisions, result load.
module cltfp_ctrl import cltfp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  logic   i_last,
    input  t_sts   i_sts,
    output logic   o_stall,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PARSE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_PARSE: begin
                if (i_valid && i_last) begin
                    n_state = i_sts.done_next ? ST_DIV_RE : ST_LOAD;
                end
            end
            ST_DIV_RE: begin
                if (i_sts.div_last) begin
                    n_state = ST_SWAP;
                end
            end
            ST_SWAP: begin
                n_state = ST_DIV_IM;
            end
            ST_DIV_IM: begin
                if (i_sts.div_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    n_state = ST_PARSE;
                end
            end
            default: begin
                n_state = ST_PARSE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_PARSE: begin
                o_stall        = 1'b0;
                o_cmd.parse    = i_valid;
                o_cmd.start_re = i_valid && i_last && i_sts.done_next;
            end
            ST_DIV_RE: begin
                o_cmd.step = 1'b1;
            end
            ST_SWAP: begin
                o_cmd.start_im = 1'b1;
            end
            ST_DIV_IM: begin
                o_cmd.step = 1'b1;
            end
            ST_LOAD: begin
                o_cmd.load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/cltfp_dp.sv -----
// Datapath: parse registers, shared fraction divider, output register.
module cltfp_dp import cltfp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [7:0]              i_char_code,
    input  logic                    i_stall,
    output t_sts                    o_sts,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_real_part,
    output logic signed [OUT_W-1:0] o_imag_part,
    output logic                    o_format_ok,
    output logic                    o_saturated
);

    // Parse state
    t_phase             r_phase,      n_phase;
    logic               r_re_neg,     n_re_neg;
    logic [WHOLE_W-1:0] r_re_whole,   n_re_whole;
    logic [FD_W-1:0]    r_re_fd,      n_re_fd;
    logic [FC_W-1:0]    r_re_fc,      n_re_fc;
    logic               r_im_neg,     n_im_neg;
    logic [WHOLE_W-1:0] r_im_whole,   n_im_whole;
    logic [FD_W-1:0]    r_im_fd,      n_im_fd;
    logic [FC_W-1:0]    r_im_fc,      n_im_fc;
    logic               r_clamp,      n_clamp;

    // Divider
    logic [P_W:0]           r_rem;
    logic [P_W-1:0]         r_div;
    logic [FRAC_BITS-1:0]   r_quo;
    logic [CNT_W-1:0]       r_cnt;
    logic [FRAC_BITS-1:0]   r_re_frac;

    // Output stage
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_real;
    logic [OUT_W-1:0]       r_out_imag;
    logic                   r_out_ok;
    logic                   r_out_sat;

    logic               is_digit;
    logic               is_sign;
    logic               is_minus;
    logic [3:0]         digit;
    logic               sel_im;
    logic               whole_upd;
    logic               frac_upd;
    logic [WHOLE_W-1:0] whole_cur;
    logic [WHOLE_W+3:0] whole_sum;
    logic [WHOLE_W-1:0] whole_new;
    logic               whole_clamp;
    logic [FD_W-1:0]    fd_cur;
    logic [FC_W-1:0]    fc_cur;
    logic [FD_W+3:0]    fd_sum;
    logic [P_W:0]       rem2;
    logic               rem_ge;
    logic               parts_ok;

    function automatic logic [OUT_W-1:0] f_part(
        input logic                 neg,
        input logic [WHOLE_W-1:0]   whole,
        input logic [FRAC_BITS-1:0] frac
    );
        logic [OUT_W-1:0] mag;
        mag = {1'b0, whole, frac};
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    assign is_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign is_minus = (i_char_code == CH_MINUS);
    assign is_sign  = (i_char_code == CH_PLUS) || is_minus;
    assign digit    = 4'(i_char_code - CH_ZERO);
    assign sel_im   = (r_phase == PH_I_START) || (r_phase == PH_I_INT)
                   || (r_phase == PH_I_FRAC);

    // One digit step for whichever part is being parsed
    assign whole_cur   = sel_im ? r_im_whole : r_re_whole;
    assign whole_sum   = (WHOLE_W+4)'(whole_cur) * (WHOLE_W+4)'(RADIX)
                       + (WHOLE_W+4)'(digit);
    assign whole_clamp = whole_sum > (WHOLE_W+4)'(WHOLE_MAX);
    assign whole_new   = whole_clamp ? WHOLE_MAX : whole_sum[WHOLE_W-1:0];
    assign fd_cur      = sel_im ? r_im_fd : r_re_fd;
    assign fc_cur      = sel_im ? r_im_fc : r_re_fc;
    assign fd_sum      = (FD_W+4)'(fd_cur) * (FD_W+4)'(RADIX) + (FD_W+4)'(digit);

    always_comb begin
        n_phase    = PH_ERROR;
        n_re_neg   = r_re_neg;
        n_re_whole = r_re_whole;
        n_re_fd    = r_re_fd;
        n_re_fc    = r_re_fc;
        n_im_neg   = r_im_neg;
        n_im_whole = r_im_whole;
        n_im_fd    = r_im_fd;
        n_im_fc    = r_im_fc;
        n_clamp    = r_clamp;
        whole_upd  = 1'b0;
        frac_upd   = 1'b0;
        case (r_phase)
            PH_R_START: begin
                if (is_sign) begin
                    n_re_neg = is_minus;
                    n_phase  = PH_R_SIGNED;
                end else if (is_digit) begin
                    whole_upd = 1'b1;
                    n_phase   = PH_R_INT;
                end
            end
            PH_R_SIGNED, PH_I_START: begin
                if (is_digit) begin
                    whole_upd = 1'b1;
                    n_phase   = (r_phase == PH_I_START) ? PH_I_INT : PH_R_INT;
                end
            end
            PH_R_INT, PH_R_FRAC: begin
                if (is_digit) begin
                    whole_upd = (r_phase == PH_R_INT);
                    frac_upd  = (r_phase == PH_R_FRAC);
                    n_phase   = r_phase;
                end else if (i_char_code == CH_DOT && r_phase == PH_R_INT) begin
                    n_phase = PH_R_FRAC;
                end else if (is_sign) begin
                    n_im_neg = is_minus;
                    n_phase  = PH_I_START;
                end
            end
            PH_I_INT, PH_I_FRAC: begin
                if (is_digit) begin
                    whole_upd = (r_phase == PH_I_INT);
                    frac_upd  = (r_phase == PH_I_FRAC);
                    n_phase   = r_phase;
                end else if (i_char_code == CH_DOT && r_phase == PH_I_INT) begin
                    n_phase = PH_I_FRAC;
                end else if (i_char_code == CH_I) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase

        if (whole_upd) begin
            if (sel_im) begin
                n_im_whole = whole_new;
            end else begin
                n_re_whole = whole_new;
            end
            n_clamp = r_clamp | whole_clamp;
        end
        // digits past the limit are dropped
        if (frac_upd && fc_cur < FC_W'(MAX_FRAC_DIGITS)) begin
            if (sel_im) begin
                n_im_fd = fd_sum[FD_W-1:0];
                n_im_fc = r_im_fc + 1'b1;
            end else begin
                n_re_fd = fd_sum[FD_W-1:0];
                n_re_fc = r_re_fc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_phase    <= PH_R_START;
            r_re_neg   <= 1'b0;
            r_re_whole <= '0;
            r_re_fd    <= '0;
            r_re_fc    <= '0;
            r_im_neg   <= 1'b0;
            r_im_whole <= '0;
            r_im_fd    <= '0;
            r_im_fc    <= '0;
            r_clamp    <= 1'b0;
        end else if (i_cmd.parse) begin
            r_phase    <= n_phase;
            r_re_neg   <= n_re_neg;
            r_re_whole <= n_re_whole;
            r_re_fd    <= n_re_fd;
            r_re_fc    <= n_re_fc;
            r_im_neg   <= n_im_neg;
            r_im_whole <= n_im_whole;
            r_im_fd    <= n_im_fd;
            r_im_fc    <= n_im_fc;
            r_clamp    <= n_clamp;
        end
    end

    // Restoring division: floor(D * 2^FRAC_BITS / 10^k), one quotient bit per cycle.
    // The remainder stays below the divisor, so D < 10^k is a valid start.
    assign rem2   = {r_rem[P_W-1:0], 1'b0};
    assign rem_ge = rem2 >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.start_re || i_cmd.start_im) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_re) begin
            r_rem <= (P_W+1)'(r_re_fd);
            r_div <= POW10[r_re_fc];
        end else if (i_cmd.start_im) begin
            r_rem     <= (P_W+1)'(r_im_fd);
            r_div     <= POW10[r_im_fc];
            r_re_frac <= r_quo;
        end else if (i_cmd.step) begin
            r_rem <= rem_ge ? (rem2 - {1'b0, r_div}) : rem2;
            r_quo <= {r_quo[FRAC_BITS-2:0], rem_ge};
        end
    end

    assign parts_ok = (r_phase == PH_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_real <= parts_ok ? f_part(r_re_neg, r_re_whole, r_re_frac) : '0;
            r_out_imag <= parts_ok ? f_part(r_im_neg, r_im_whole, r_quo) : '0;
            r_out_ok   <= parts_ok;
            r_out_sat  <= parts_ok && r_clamp;
        end
    end

    assign o_sts.done_next = (n_phase == PH_DONE);
    assign o_sts.div_last  = (r_cnt == CNT_W'(FRAC_BITS - 1));
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    assign o_valid     = r_out_valid;
    assign o_real_part = r_out_real;
    assign o_imag_part = r_out_imag;
    assign o_format_ok = r_out_ok;
    assign o_saturated = r_out_sat;

endmodule

// ----- hdl/complex_literal_to_fixed_point.sv -----
// Top level: ASCII complex literal to signed fixed-point real and imaginary parts.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------------
//  input   | i_valid / o_stall  | i_char_code[7:0], i_last
//  output  | o_valid / i_stall  | o_real_part, o_imag_part, o_format_ok, o_saturated
//
// A character beat is taken whenever i_valid is high and o_stall is low.
// A last beat of a well-formed literal runs two fraction divisions on the shared
// restoring divider (ST_DIV_RE, ST_SWAP, ST_DIV_IM) before the result is loaded;
// a malformed literal goes straight to the load. o_stall is high meanwhile.
// The load also waits while a previous result is held by i_stall.
// Synchronous active-low reset; parse state also clears at every result load.
module complex_literal_to_fixed_point import cltfp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_char_code,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_real_part,
    output logic signed [OUT_W-1:0] o_imag_part,
    output logic                    o_format_ok,
    output logic                    o_saturated
);

    t_cmd cmd;
    t_sts sts;

    cltfp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    cltfp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_char_code (i_char_code),
        .i_stall     (i_stall),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_real_part (o_real_part),
        .o_imag_part (o_imag_part),
        .o_format_ok (o_format_ok),
        .o_saturated (o_saturated)
    );

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_format_ok) |-> (o_real_part == '0 && o_imag_part == '0
                                       && !o_saturated))
        else $error("malformed result not zero");

    a_sat_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> o_format_ok)
        else $error("saturated flag on malformed result");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last) |=> o_stall)
        else $error("input not held off after last beat");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load) |=> !cmd.load)
        else $error("result loaded twice");

endmodule
